// ----- hw/rtl/horspool_string_matcher_assert.svh -----
// Assertion macros for the Horspool matcher.
// No dependencies; uses i_clk and i_rst_n of the including module.
`ifndef HORSPOOL_STRING_MATCHER_ASSERT_SVH
`define HORSPOOL_STRING_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HSM_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HSM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hsm_pkg.sv -----
// Shared types and constants of the Horspool matcher.
// No dependencies.
`timescale 1ns / 1ps

package hsm_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 11;
    localparam int unsigned CNT_W    = 19;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND_PATTERN = 2'd0,
        ACT_APPEND_TEXT    = 2'd1,
        ACT_FIND           = 2'd2,
        ACT_CLEAR          = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_MATCH    = 2'd1,
        ST_FINISHED = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_PAT_RD,
        S_PAT_WR,
        S_START,
        S_WINDOW,
        S_CMP_RD,
        S_CMP_CHK,
        S_SHIFT_RD,
        S_SHIFT_ADD
    } t_state;

endpackage

// ----- hw/rtl/hsm_in_if.sv -----
// Input channel of the Horspool matcher: valid/ready with action and letter.
// Depends on hsm_pkg.
`timescale 1ns / 1ps

interface hsm_in_if;
    logic                          valid;
    logic                          ready;
    logic [hsm_pkg::ACTION_W-1:0]  action;
    logic [hsm_pkg::LETTER_W-1:0]  letter;

    modport source (output valid, output action, output letter, input ready);
    modport sink   (input valid, input action, input letter, output ready);
endinterface

// ----- hw/rtl/hsm_out_if.sv -----
// Result channel of the Horspool matcher: valid/ready with status, position, count.
// Depends on hsm_pkg.
`timescale 1ns / 1ps

interface hsm_out_if;
    logic                          valid;
    logic                          ready;
    logic [hsm_pkg::STATUS_W-1:0]  status;
    logic [hsm_pkg::POS_W-1:0]     match_position;
    logic [hsm_pkg::CNT_W-1:0]     comparisons;

    modport source (output valid, output status, output match_position,
                    output comparisons, input ready);
    modport sink   (input valid, input status, input match_position,
                    input comparisons, output ready);
endinterface

// ----- hw/rtl/hsm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module hsm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/horspool_string_matcher.sv -----
// Horspool matcher top level: sequencer, search registers and the three stores.
// Depends on hsm_pkg, hsm_in_if, hsm_out_if, hsm_ram and the assertion header.
`timescale 1ns / 1ps

// Boyer-Moore-Horspool search over letter codes 0 .. ALPHABET_SIZE-1. Each
// input word appends a pattern letter, appends a text letter, clears both
// stores, or asks for the next match; every input word yields exactly one
// result word (status, match start, running comparison count). Appends and
// clear answer in the cycle after acceptance. A find that follows any change
// to the stores first rebuilds the shift table: it fills every entry with the
// pattern length, then writes one entry per pattern letter but the last. The
// search itself then sets up once, and per window checks the window end,
// reads and checks each letter compared, then fetches the shift and slides
// the window; the time is data dependent. Every step is bound by the
// registered read of the pattern, text and shift memories (one read each per
// cycle). One item is worked on at a time; a new word is taken only when the
// sequencer is idle and the result register is free or being emptied. There
// is no clearing pass after reset: stores are only read below their fill
// counts and the shift table is fully rewritten before use.

`include "horspool_string_matcher_assert.svh"

module horspool_string_matcher #(
    parameter int unsigned PATTERN_DEPTH = 128,
    parameter int unsigned TEXT_DEPTH    = 2048,
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hsm_in_if.sink    i_item,
    hsm_out_if.source o_result
);

    localparam int unsigned LW   = hsm_pkg::LETTER_W;
    localparam int unsigned PAW  = $clog2(PATTERN_DEPTH);
    localparam int unsigned TAW  = $clog2(TEXT_DEPTH);
    localparam int unsigned AAW  = $clog2(ALPHABET_SIZE);
    localparam int unsigned PL_W = $clog2(PATTERN_DEPTH + 1);   // also shift entry width
    localparam int unsigned TL_W = $clog2(TEXT_DEPTH + 1);
    // window end never passes last text index plus one full shift
    localparam int unsigned WE_W = $clog2(TEXT_DEPTH + PATTERN_DEPTH);
    localparam int unsigned AL_W = 9;                            // holds ALPHABET_SIZE

    // ---- control state ----
    hsm_pkg::t_state r_state, n_state;
    logic [PL_W-1:0]            r_plen, n_plen;
    logic [TL_W-1:0]            r_tlen, n_tlen;
    logic [WE_W-1:0]            r_wend, n_wend;
    logic [hsm_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_built, n_built;
    logic                       r_done, n_done;
    logic                       r_out_valid;

    // ---- working registers (no reset needed) ----
    logic [PAW-1:0]             r_paddr, n_paddr;
    logic [TAW-1:0]             r_taddr, n_taddr;
    logic [AAW-1:0]             r_fidx, n_fidx;
    logic [LW-1:0]              r_tail, n_tail;
    logic                       r_first, n_first;
    logic                       r_matched, n_matched;
    hsm_pkg::t_status           r_out_status;
    logic [hsm_pkg::POS_W-1:0]  r_out_pos;
    logic [hsm_pkg::CNT_W-1:0]  r_out_cnt;

    // ---- result to load ----
    logic                       n_emit;
    hsm_pkg::t_status           n_status;
    logic [hsm_pkg::POS_W-1:0]  n_pos;

    // ---- memory ports ----
    logic            pat_we;
    logic [LW-1:0]   pat_rdata;
    logic            txt_we;
    logic [LW-1:0]   txt_rdata;
    logic            shf_we;
    logic [AAW-1:0]  shf_waddr;
    logic [PL_W-1:0] shf_wdata;
    logic [AAW-1:0]  shf_raddr;
    logic [PL_W-1:0] shf_rdata;

    // ---- helpers ----
    logic                       accept;
    hsm_pkg::t_action           act;
    logic                       letter_ok;
    logic [LW+AAW-1:0]          tail_ext;
    logic [LW+AAW-1:0]          pat_ext;
    logic [TAW+hsm_pkg::POS_W-1:0] taddr_ext;
    logic                       no_search;
    logic [PL_W-1:0]            paddr_ext;

    assign accept    = i_item.valid && i_item.ready;
    assign act       = hsm_pkg::t_action'(i_item.action);
    assign letter_ok = AL_W'(i_item.letter) < AL_W'(ALPHABET_SIZE);
    assign tail_ext  = {{AAW{1'b0}}, r_tail};
    assign pat_ext   = {{AAW{1'b0}}, pat_rdata};
    assign shf_raddr = tail_ext[AAW-1:0];
    assign taddr_ext = {{hsm_pkg::POS_W{1'b0}}, r_taddr};
    assign paddr_ext = PL_W'(r_paddr);
    // search already finished, empty pattern, or pattern longer than the text
    assign no_search = r_done || (r_plen == '0) || (WE_W'(r_plen) > WE_W'(r_tlen));

    assign i_item.ready = (r_state == hsm_pkg::S_IDLE) && (!r_out_valid || o_result.ready);

    // ---- stores ----
    hsm_ram #(.WIDTH(LW), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_plen[PAW-1:0]),
        .i_wdata (i_item.letter),
        .i_raddr (r_paddr),
        .o_rdata (pat_rdata)
    );

    hsm_ram #(.WIDTH(LW), .DEPTH(TEXT_DEPTH)) u_txt_ram (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (r_tlen[TAW-1:0]),
        .i_wdata (i_item.letter),
        .i_raddr (r_taddr),
        .o_rdata (txt_rdata)
    );

    hsm_ram #(.WIDTH(PL_W), .DEPTH(ALPHABET_SIZE)) u_shf_ram (
        .i_clk   (i_clk),
        .i_we    (shf_we),
        .i_waddr (shf_waddr),
        .i_wdata (shf_wdata),
        .i_raddr (shf_raddr),
        .o_rdata (shf_rdata)
    );

    // ---- sequencer: next state and datapath ----
    always_comb begin
        n_state   = r_state;
        n_plen    = r_plen;
        n_tlen    = r_tlen;
        n_wend    = r_wend;
        n_cnt     = r_cnt;
        n_built   = r_built;
        n_done    = r_done;
        n_paddr   = r_paddr;
        n_taddr   = r_taddr;
        n_fidx    = r_fidx;
        n_tail    = r_tail;
        n_first   = r_first;
        n_matched = r_matched;
        n_emit    = 1'b0;
        n_status  = hsm_pkg::ST_ACCEPTED;
        n_pos     = '0;
        pat_we    = 1'b0;
        txt_we    = 1'b0;
        shf_we    = 1'b0;
        shf_waddr = r_fidx;
        shf_wdata = r_plen;

        unique case (r_state)
            hsm_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (act)
                        hsm_pkg::ACT_APPEND_PATTERN: begin
                            n_emit = 1'b1;
                            if (!letter_ok || (r_plen >= PL_W'(PATTERN_DEPTH))) begin
                                n_status = hsm_pkg::ST_OVERFLOW;
                            end else begin
                                pat_we  = 1'b1;
                                n_plen  = r_plen + PL_W'(1);
                                n_wend  = '0;
                                n_cnt   = '0;
                                n_built = 1'b0;
                                n_done  = 1'b0;
                            end
                        end
                        hsm_pkg::ACT_APPEND_TEXT: begin
                            n_emit = 1'b1;
                            if (!letter_ok || (r_tlen >= TL_W'(TEXT_DEPTH))) begin
                                n_status = hsm_pkg::ST_OVERFLOW;
                            end else begin
                                txt_we  = 1'b1;
                                n_tlen  = r_tlen + TL_W'(1);
                                n_wend  = '0;
                                n_cnt   = '0;
                                n_built = 1'b0;
                                n_done  = 1'b0;
                            end
                        end
                        hsm_pkg::ACT_FIND: begin
                            if (!r_built) begin
                                n_fidx  = '0;
                                n_state = hsm_pkg::S_FILL;
                            end else begin
                                n_state = hsm_pkg::S_START;
                            end
                        end
                        hsm_pkg::ACT_CLEAR: begin
                            n_emit  = 1'b1;
                            n_plen  = '0;
                            n_tlen  = '0;
                            n_wend  = '0;
                            n_cnt   = '0;
                            n_built = 1'b0;
                            n_done  = 1'b0;
                        end
                    endcase
                end
            end

            // every entry gets the pattern length
            hsm_pkg::S_FILL: begin
                shf_we = 1'b1;
                n_fidx = r_fidx + AAW'(1);
                if (r_fidx == AAW'(ALPHABET_SIZE - 1)) begin
                    n_wend  = (r_plen != '0) ? WE_W'(r_plen - PL_W'(1)) : '0;
                    n_cnt   = '0;
                    n_done  = 1'b0;
                    n_built = 1'b1;
                    n_paddr = '0;
                    n_state = (r_plen >= PL_W'(2)) ? hsm_pkg::S_PAT_RD : hsm_pkg::S_START;
                end
            end

            hsm_pkg::S_PAT_RD: begin
                n_state = hsm_pkg::S_PAT_WR;
            end

            // later pattern positions overwrite earlier ones
            hsm_pkg::S_PAT_WR: begin
                shf_we    = 1'b1;
                shf_waddr = pat_ext[AAW-1:0];
                shf_wdata = r_plen - paddr_ext - PL_W'(1);
                if (paddr_ext + PL_W'(2) == r_plen) begin
                    n_state = hsm_pkg::S_START;
                end else begin
                    n_paddr = r_paddr + PAW'(1);
                    n_state = hsm_pkg::S_PAT_RD;
                end
            end

            hsm_pkg::S_START: begin
                if (no_search) begin
                    n_done   = 1'b1;
                    n_emit   = 1'b1;
                    n_status = hsm_pkg::ST_FINISHED;
                    n_state  = hsm_pkg::S_IDLE;
                end else begin
                    n_state = hsm_pkg::S_WINDOW;
                end
            end

            hsm_pkg::S_WINDOW: begin
                if (r_wend < WE_W'(r_tlen)) begin
                    n_paddr   = PAW'(r_plen - PL_W'(1));
                    n_taddr   = r_wend[TAW-1:0];
                    n_first   = 1'b1;
                    n_matched = 1'b0;
                    n_state   = hsm_pkg::S_CMP_RD;
                end else begin
                    n_done   = 1'b1;
                    n_emit   = 1'b1;
                    n_status = hsm_pkg::ST_FINISHED;
                    n_state  = hsm_pkg::S_IDLE;
                end
            end

            hsm_pkg::S_CMP_RD: begin
                n_state = hsm_pkg::S_CMP_CHK;
            end

            // right-to-left compare; letter under the window end picks the shift
            hsm_pkg::S_CMP_CHK: begin
                if (r_cnt != '1) begin
                    n_cnt = r_cnt + hsm_pkg::CNT_W'(1);
                end
                if (r_first) begin
                    n_tail  = txt_rdata;
                    n_first = 1'b0;
                end
                priority if (pat_rdata != txt_rdata) begin
                    n_state = hsm_pkg::S_SHIFT_RD;
                end else if (r_paddr == '0) begin
                    n_matched = 1'b1;                 // r_taddr now holds the match start
                    n_state   = hsm_pkg::S_SHIFT_RD;
                end else begin
                    n_paddr = r_paddr - PAW'(1);
                    n_taddr = r_taddr - TAW'(1);
                    n_state = hsm_pkg::S_CMP_RD;
                end
            end

            hsm_pkg::S_SHIFT_RD: begin
                n_state = hsm_pkg::S_SHIFT_ADD;
            end

            hsm_pkg::S_SHIFT_ADD: begin
                n_wend = r_wend + WE_W'(shf_rdata);
                if (r_matched) begin
                    n_emit   = 1'b1;
                    n_status = hsm_pkg::ST_MATCH;
                    n_pos    = taddr_ext[hsm_pkg::POS_W-1:0];
                    n_state  = hsm_pkg::S_IDLE;
                end else begin
                    n_state = hsm_pkg::S_WINDOW;
                end
            end

            default: begin
                n_state = hsm_pkg::S_IDLE;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsm_pkg::S_IDLE;
            r_plen      <= '0;
            r_tlen      <= '0;
            r_wend      <= '0;
            r_cnt       <= '0;
            r_built     <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
            r_tlen  <= n_tlen;
            r_wend  <= n_wend;
            r_cnt   <= n_cnt;
            r_built <= n_built;
            r_done  <= n_done;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- working and result registers ----
    always_ff @(posedge i_clk) begin
        r_paddr   <= n_paddr;
        r_taddr   <= n_taddr;
        r_fidx    <= n_fidx;
        r_tail    <= n_tail;
        r_first   <= n_first;
        r_matched <= n_matched;
        if (n_emit) begin
            r_out_status <= n_status;
            r_out_pos    <= n_pos;
            r_out_cnt    <= n_cnt;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out_status;
    assign o_result.match_position = r_out_pos;
    assign o_result.comparisons    = r_out_cnt;

    // ---- checks ----
    `HSM_ASSERT_IMPL(a_slot_free, i_item.valid && i_item.ready, !r_out_valid || o_result.ready, "word taken while result slot full")
    `HSM_ASSERT_IMPL(a_busy_stalls, r_state != hsm_pkg::S_IDLE, !i_item.ready, "input ready while searching")
    `HSM_ASSERT_NEXT(a_append_answers, i_item.valid && i_item.ready && (i_item.action == hsm_pkg::ACT_APPEND_PATTERN || i_item.action == hsm_pkg::ACT_APPEND_TEXT), o_result.valid, "append gave no result next cycle")
    `HSM_ASSERT_IMPL(a_pos_zero, o_result.valid && o_result.status != hsm_pkg::ST_MATCH, o_result.match_position == '0, "position set without a match")

endmodule

// ----- tb/horspool_string_matcher_checker.sv -----
// Scoreboard for the Horspool matcher: predicts one result word per input word and compares.
// Depends on hsm_pkg, hsm_in_if and hsm_out_if.
`timescale 1ns / 1ps

module horspool_string_matcher_checker #(
    parameter int unsigned PATTERN_DEPTH = 128,
    parameter int unsigned TEXT_DEPTH    = 2048,
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hsm_in_if     i_item,
    hsm_out_if    i_result,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);
    import hsm_pkg::*;

    localparam int unsigned COUNT_MAX = (1 << CNT_W) - 1;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
    } t_search_result;

    // Shadow of the matcher state
    logic [LETTER_W-1:0] pat_mem [PATTERN_DEPTH];
    logic [LETTER_W-1:0] txt_mem [TEXT_DEPTH];
    logic [7:0]          skip    [ALPHABET_SIZE];
    int unsigned         pat_len;
    int unsigned         txt_len;
    int unsigned         win_end;
    int unsigned         cmp_count;
    bit                  tbl_ok;
    bit                  exhausted;

    t_search_result      awaited_q [$];
    t_search_result      want;
    int                  fails;
    int                  checked;

    function automatic void restart_search();
        win_end   = 0;
        cmp_count = 0;
        tbl_ok    = 1'b0;
        exhausted = 1'b0;
    endfunction

    function automatic t_search_result predict_search(t_action act, logic [LETTER_W-1:0] ltr);
        t_search_result r;
        int unsigned    k;
        int unsigned    j;
        int unsigned    here;
        bit             found;
        r.status   = ST_ACCEPTED;
        r.position = '0;
        found      = 1'b0;
        case (act)
            ACT_APPEND_PATTERN: begin
                if (ltr >= ALPHABET_SIZE || pat_len >= PATTERN_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    pat_mem[pat_len] = ltr;
                    pat_len++;
                    restart_search();
                end
            end
            ACT_APPEND_TEXT: begin
                if (ltr >= ALPHABET_SIZE || txt_len >= TEXT_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    txt_mem[txt_len] = ltr;
                    txt_len++;
                    restart_search();
                end
            end
            ACT_FIND: begin
                if (!tbl_ok) begin
                    for (k = 0; k < ALPHABET_SIZE; k++)
                        skip[k] = pat_len[7:0];
                    for (k = 0; k + 1 < pat_len; k++)
                        skip[pat_mem[k]] = 8'(pat_len - k - 1);
                    win_end   = (pat_len != 0) ? pat_len - 1 : 0;
                    cmp_count = 0;
                    exhausted = 1'b0;
                    tbl_ok    = 1'b1;
                end
                if (exhausted || pat_len == 0 || pat_len > txt_len) begin
                    exhausted = 1'b1;
                    r.status  = ST_FINISHED;
                end else begin
                    while (!found && win_end < txt_len) begin
                        here = win_end;
                        for (j = 0; j < pat_len; j++) begin
                            if (cmp_count < COUNT_MAX)
                                cmp_count++;
                            if (pat_mem[pat_len - 1 - j] != txt_mem[here - j])
                                break;
                        end
                        win_end = here + skip[txt_mem[here]];
                        if (j == pat_len) begin
                            found      = 1'b1;
                            r.status   = ST_MATCH;
                            r.position = POS_W'(here + 1 - pat_len);
                        end
                    end
                    if (!found) begin
                        exhausted = 1'b1;
                        r.status  = ST_FINISHED;
                    end
                end
            end
            default: begin
                pat_len = 0;
                txt_len = 0;
                restart_search();
            end
        endcase
        r.count = CNT_W'(cmp_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
        $display("MISMATCH %s: got %0d, expected %0d (result word %0d)",
                 what, got, exp_val, checked);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_len = 0;
            txt_len = 0;
            restart_search();
            awaited_q.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_item.valid && i_item.ready)
                awaited_q.push_back(predict_search(t_action'(i_item.action), i_item.letter));
            if (i_result.valid && i_result.ready) begin
                if (awaited_q.size() == 0) begin
                    report_mismatch("result word with nothing awaited", i_result.status, 0);
                end else begin
                    want = awaited_q.pop_front();
                    if (i_result.status !== want.status)
                        report_mismatch("status", i_result.status, want.status);
                    if (i_result.match_position !== want.position)
                        report_mismatch("match_position", i_result.match_position,
                                        want.position);
                    if (i_result.comparisons !== want.count)
                        report_mismatch("comparisons", i_result.comparisons, want.count);
                end
                checked++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_q.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/horspool_string_matcher_tb.sv -----
// Top of the Horspool matcher bench: clock, reset, word stimulus and the verdict.
// Depends on hsm_pkg, both channel interfaces, the matcher RTL and the scoreboard.
`timescale 1ns / 1ps

module horspool_string_matcher_tb;
    import hsm_pkg::*;

    localparam int unsigned PATTERN_DEPTH = 128;
    localparam int unsigned TEXT_DEPTH    = 2048;
    localparam int unsigned ALPHABET_SIZE = 26;

    // Random words, split over three idling regimes; the capacity run adds
    // about TEXT_DEPTH + PATTERN_DEPTH words on top
    localparam int unsigned RANDOM_WORDS  = 600;
    // Finds here run over texts of up to TEXT_DEPTH letters, and a table
    // rebuild may cover a full pattern; the limit leaves plenty of margin.
    localparam int unsigned STALL_LIMIT   = 50000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    hsm_in_if  item_ch ();
    hsm_out_if result_ch ();

    int fail_count;
    int pending;
    int checked;

    int words_sent    = 0;
    int sender_idle   = 0;   // percent of cycles the sender holds back
    int receiver_idle = 0;   // percent of cycles the receiver is not ready
    int idle_cycles   = 0;
    bit start_hold    = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;

    horspool_string_matcher #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TEXT_DEPTH    (TEXT_DEPTH),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    horspool_string_matcher_checker #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TEXT_DEPTH    (TEXT_DEPTH),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Result side. A one-off long hold-off lets the single result register
    // fill so the matcher has to drop its input ready while words keep coming.
    always @(posedge i_clk) begin
        if (start_hold && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    // Watchdog: any handshake on either channel resets the count
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one word and returns once it has been taken. Valid stays high on
    // return, so back-to-back words go out without a gap unless the idle draw
    // says otherwise.
    task automatic send_word(t_action act, logic [LETTER_W-1:0] ltr);
        while ($urandom_range(0, 99) < sender_idle) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.letter <= ltr;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    // Both stores to capacity and one past. The text ends in a copy of the
    // pattern so the only match sits at the highest possible start index.
    task automatic fill_stores();
        logic [LETTER_W-1:0] pat [PATTERN_DEPTH];
        int unsigned         k;
        send_word(ACT_CLEAR, 5'd0);
        for (k = 0; k < PATTERN_DEPTH; k++) begin
            pat[k] = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
            send_word(ACT_APPEND_PATTERN, pat[k]);
        end
        send_word(ACT_APPEND_PATTERN, 5'd25);          // store full
        for (k = 0; k < TEXT_DEPTH; k++) begin
            if (k >= TEXT_DEPTH - PATTERN_DEPTH)
                send_word(ACT_APPEND_TEXT, pat[k - (TEXT_DEPTH - PATTERN_DEPTH)]);
            else
                send_word(ACT_APPEND_TEXT,
                          LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1)));
        end
        send_word(ACT_APPEND_TEXT, 5'd0);              // store full
        repeat (3) send_word(ACT_FIND, 5'd0);          // match, finished, finished again
    endtask

    // One search: clear, build pattern and text interleaved, then a run of
    // finds with the odd append thrown in to restart the search midway.
    // Small alphabets make matches frequent; a few letters fall outside the
    // alphabet to exercise the ignored-append path.
    task automatic run_search();
        int unsigned         span;
        int unsigned         plen;
        int unsigned         tlen;
        int unsigned         finds;
        int unsigned         k;
        logic [LETTER_W-1:0] ltr;
        span  = ($urandom_range(0, 3) == 0) ? ALPHABET_SIZE : $urandom_range(1, 3);
        plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
        tlen  = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 300)
                                             : $urandom_range(0, 40);
        finds = $urandom_range(2, 12);
        send_word(ACT_CLEAR, LETTER_W'($urandom_range(0, 31)));
        while (plen + tlen != 0) begin
            ltr = ($urandom_range(0, 39) == 0) ? LETTER_W'($urandom_range(ALPHABET_SIZE, 31))
                                               : LETTER_W'($urandom_range(0, span - 1));
            if (plen != 0 && (tlen == 0 || $urandom_range(0, 3) == 0)) begin
                send_word(ACT_APPEND_PATTERN, ltr);
                plen--;
            end else begin
                send_word(ACT_APPEND_TEXT, ltr);
                tlen--;
            end
        end
        for (k = 0; k < finds; k++) begin
            case ($urandom_range(0, 15))
                0:       send_word(ACT_APPEND_TEXT, LETTER_W'($urandom_range(0, span - 1)));
                1:       send_word(ACT_APPEND_PATTERN, LETTER_W'($urandom_range(0, span - 1)));
                default: send_word(ACT_FIND, LETTER_W'($urandom_range(0, 31)));
            endcase
        end
    endtask

    initial begin
        int target;
        item_ch.valid   = 1'b0;
        item_ch.action  = ACT_APPEND_PATTERN;
        item_ch.letter  = '0;
        result_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: sender mostly busy, receiver mostly stalling
        sender_idle   = 11;
        receiver_idle = 85;
        send_word(ACT_CLEAR, 5'd0);
        send_word(ACT_FIND, 5'd0);                     // empty pattern
        send_word(ACT_FIND, 5'd31);                    // find after finish
        send_word(ACT_APPEND_PATTERN, 5'd31);          // outside alphabet
        send_word(ACT_APPEND_PATTERN, 5'd26);
        send_word(ACT_APPEND_TEXT, 5'd16);
        send_word(ACT_APPEND_PATTERN, 5'd0);
        send_word(ACT_APPEND_PATTERN, 5'd1);
        send_word(ACT_APPEND_PATTERN, 5'd0);
        send_word(ACT_FIND, 5'd0);                     // pattern longer than text
        send_word(ACT_APPEND_TEXT, 5'd25);
        send_word(ACT_APPEND_TEXT, 5'd0);
        send_word(ACT_APPEND_TEXT, 5'd1);
        send_word(ACT_APPEND_TEXT, 5'd0);
        send_word(ACT_APPEND_TEXT, 5'd1);
        send_word(ACT_APPEND_TEXT, 5'd0);
        repeat (4) send_word(ACT_FIND, 5'd0);          // two matches, then finished twice
        send_word(ACT_APPEND_TEXT, 5'd1);              // restarts a finished search
        send_word(ACT_FIND, 5'd0);
        send_word(ACT_APPEND_PATTERN, 5'd15);          // restarts a live search
        send_word(ACT_FIND, 5'd0);
        send_word(ACT_CLEAR, 5'd31);
        send_word(ACT_FIND, 5'd0);

        // Capacity run at full speed
        sender_idle   = 0;
        receiver_idle = 0;
        fill_stores();

        // Random searches in three idling regimes
        target = words_sent + RANDOM_WORDS / 3;
        sender_idle   = 11;
        receiver_idle = 85;
        while (words_sent < target)
            run_search();

        target = words_sent + RANDOM_WORDS / 3;
        sender_idle   = 85;
        receiver_idle = 11;
        while (words_sent < target)
            run_search();

        target = words_sent + RANDOM_WORDS / 3;
        sender_idle   = 0;
        receiver_idle = 0;
        start_hold    = 1'b1;                          // back-pressure burst
        while (words_sent < target)
            run_search();

        item_ch.valid <= 1'b0;
        // let the count of awaited words catch up with the last acceptance
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words and checked %0d result words", words_sent, checked);
        $display("Covered overflow, full stores, restarts, finished searches and back-pressure");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
